### hdl/urmv_pkg.sv
// Shared types and constants for the majority-vote serial receiver.
// Used by urmv_sampler, urmv_tally and uart_receiver_majority_vote.
package urmv_pkg;

	localparam int unsigned DATA_BITS = 8;

	localparam logic [7:0] NO_WINNER = 8'hFF;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	localparam logic [7:0] REG_HALF_BIT_TICKS = 8'd0;
	localparam logic [7:0] REG_VOTE_COUNT     = 8'd1;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_DATA  = 2'd1,
		PH_TRAIL = 2'd2
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} tally_req_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
		logic       round_done;
		logic [7:0] voted_byte;
		logic       no_majority;
	} tally_res_t;

endpackage

### hdl/urmv_sampler.sv
// Line sampler: bit timing, start detection and data bit assembly.
// Depends on urmv_pkg; issues one tally request per received byte.
module urmv_sampler
	import urmv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             level,
	input  logic [15:0]      half_bit_ticks,
	output tally_req_t       req
);

	phase_t      phase_q, phase_d;
	logic [16:0] tick_q, tick_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] half;
	logic [16:0] full_reload;
	logic [3:0]  bit_inc;

	assign half        = (half_bit_ticks == 16'd0) ? 16'd1 : half_bit_ticks;
	assign full_reload = {half, 1'b0} - 17'd1;
	assign bit_inc     = bit_q + 4'd1;

	assign req.valid = accept && (tick_q == 17'd0) && (phase_q == PH_TRAIL);
	assign req.data  = shift_q;

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		if (tick_q != 17'd0) begin
			tick_d = tick_q - 17'd1;
		end else begin
			case (phase_q)
				PH_DATA: begin
					if (bit_q < 4'd8) begin
						shift_d[bit_q[2:0]] = shift_q[bit_q[2:0]] | level;
					end
					bit_d  = bit_inc;
					tick_d = full_reload;
					if (bit_inc >= 4'(DATA_BITS)) begin
						phase_d = PH_TRAIL;
					end
				end
				default: begin
					// hunt for a low level; also closes the stop-bit wait
					if (!level) begin
						phase_d = PH_DATA;
						tick_d  = full_reload;
						bit_d   = 4'd0;
						shift_d = 8'd0;
					end else begin
						phase_d = PH_HUNT;
						tick_d  = {1'b0, half - 16'd1};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			tick_q  <= 17'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
		end
	end

endmodule

### hdl/urmv_tally.sv
// Byte count table and vote round logic around a 256x8 synchronous memory.
// Depends on urmv_pkg; read when a request is taken, modify and write back in stage s1.
module urmv_tally
	import urmv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  tally_req_t req,
	input  logic [7:0] vote_count,
	input  logic       out_hold,
	output logic       stall,
	output tally_res_t res
);

	logic [7:0]   mem [256];
	logic [7:0]   rd_data_q;
	logic         fwd_q;
	logic [7:0]   fwd_data_q;
	logic [255:0] valid_q;
	logic         s1_valid_q;
	logic [7:0]   s1_byte_q;
	logic [7:0]   bir_q;
	logic [7:0]   winner_q;
	logic         found_q;

	logic       wr_en;
	logic [7:0] stored, cnt_old, cnt_new, bir_next, winner_new;
	logic       wins, found_new, done;

	assign stall = s1_valid_q && out_hold;
	assign wr_en = s1_valid_q && !out_hold;

	assign stored     = fwd_q ? fwd_data_q : rd_data_q;
	assign cnt_old    = valid_q[s1_byte_q] ? stored : 8'd0;
	assign cnt_new    = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + 8'd1;
	assign bir_next   = bir_q + 8'd1;
	assign wins       = {cnt_new, 1'b0} > {1'b0, vote_count};
	assign found_new  = found_q || wins;
	assign winner_new = wins ? s1_byte_q : winner_q;
	assign done       = (bir_next == 8'd0) || (bir_next >= vote_count);

	always_comb begin
		res.valid       = wr_en;
		res.rx_byte     = s1_byte_q;
		res.round_done  = done;
		res.voted_byte  = 8'd0;
		res.no_majority = 1'b0;
		if (done) begin
			res.voted_byte  = found_new ? winner_new : NO_WINNER;
			res.no_majority = !found_new;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[s1_byte_q] <= cnt_new;
		end
		if (req.valid) begin
			rd_data_q  <= mem[req.data];
			fwd_q      <= wr_en && (s1_byte_q == req.data);
			fwd_data_q <= cnt_new;
		end
		if (req.valid) begin
			s1_byte_q <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			valid_q    <= '0;
			bir_q      <= 8'd0;
			winner_q   <= NO_WINNER;
			found_q    <= 1'b0;
		end else begin
			if (!stall) begin
				s1_valid_q <= req.valid;
			end
			if (wr_en) begin
				if (done) begin
					valid_q  <= '0;
					bir_q    <= 8'd0;
					winner_q <= NO_WINNER;
					found_q  <= 1'b0;
				end else begin
					valid_q[s1_byte_q] <= 1'b1;
					bir_q              <= bir_next;
					winner_q           <= winner_new;
					found_q            <= found_new;
				end
			end
		end
	end

endmodule

### hdl/uart_receiver_majority_vote.sv
// Top level of the 8N1 serial receiver with majority vote over repeated bytes.
// Depends on urmv_pkg, urmv_sampler and urmv_tally.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[0] rx_level
// m_*      out  m_tvalid/m_tready  m_tdata rx_byte, voted_byte; m_tuser round_done,
//                                  no_majority
// cfg_*    in   cfg_valid/ready    cfg_index register, cfg_data value
//
// One line sample is taken per cycle while s_tready is high.
// The result of a byte shows on m_tvalid after its stop-bit sample transfers:
// the count memory is read at that transfer edge, and the write back in stage s1
// then loads the output register unless the output register is held.
// Reset clears the count valid bitmap at once; no clearing pass is needed.
// s_tready drops only while a finished byte waits behind a full output register.
module uart_receiver_majority_vote
	import urmv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] rx_level, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] rx_byte, [15:8] voted_byte
	output logic [1:0]  m_tuser,   // [0] round_done, [1] no_majority
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] half_bit_ticks_q;
	logic [7:0]  vote_count_q;
	logic        accept;
	logic        stall;
	logic        out_hold;
	tally_req_t  req;
	tally_res_t  res;

	logic        out_valid_q;
	logic [15:0] out_data_q;
	logic [1:0]  out_user_q;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_ticks_q <= 16'd1;
			vote_count_q     <= 8'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HALF_BIT_TICKS: half_bit_ticks_q <= cfg_data;
				REG_VOTE_COUNT:     vote_count_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Hold the input only while the tally stage cannot drain.
	assign s_tready = !stall;
	assign accept   = s_tvalid && s_tready;
	assign out_hold = out_valid_q && !m_tready;

	urmv_sampler u_sampler (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.level          (s_tdata[0]),
		.half_bit_ticks (half_bit_ticks_q),
		.req            (req)
	);

	urmv_tally u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.vote_count (vote_count_q),
		.out_hold   (out_hold),
		.stall      (stall),
		.res        (res)
	);

	// Output register: load a finished byte, drop it once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_data_q <= {res.voted_byte, res.rx_byte};
			out_user_q <= {res.no_majority, res.round_done};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!out_valid_q || m_tready))
		else $error("result loaded over an untaken result");

	a_plain_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[15:8] == 8'd0 && !m_tuser[1]))
		else $error("vote fields set outside a round end");

	a_no_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tdata[15:8] == NO_WINNER))
		else $error("no-majority flag without round end marker");
`endif

endmodule
